// ===== rtl/sit_pkg.sv =====
`default_nettype none
package sit_pkg;

  // How the operands of the cross-product units are to be read
  localparam logic [1:0] MODE_NONE = 2'd0;  // both lines vertical: never a hit
  localparam logic [1:0] MODE_GEN  = 2'd1;  // general case, t and u over a common denominator
  localparam logic [1:0] MODE_VERT = 2'd2;  // exactly one segment vertical

  localparam int NUM_CROSS = 5;

  typedef struct packed {
    logic neg;  // value below zero
    logic nz;   // value not zero
  } sign_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       btw;   // vertical x lies within the other segment's x range
  } ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sit_ifs.sv =====
`default_nettype none
interface seg_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x;
  logic signed [COORD_WIDTH-1:0] a_y;
  logic signed [COORD_WIDTH-1:0] b_x;
  logic signed [COORD_WIDTH-1:0] b_y;
  logic signed [COORD_WIDTH-1:0] c_x;
  logic signed [COORD_WIDTH-1:0] c_y;
  logic signed [COORD_WIDTH-1:0] d_x;
  logic signed [COORD_WIDTH-1:0] d_y;

  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
  modport sink (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface

interface hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface
`default_nettype wire

// ===== rtl/sit_prep.sv =====
`default_nettype none
module sit_prep #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [COORD_WIDTH-1:0] a_x,
  input  wire logic signed [COORD_WIDTH-1:0] a_y,
  input  wire logic signed [COORD_WIDTH-1:0] b_x,
  input  wire logic signed [COORD_WIDTH-1:0] b_y,
  input  wire logic signed [COORD_WIDTH-1:0] c_x,
  input  wire logic signed [COORD_WIDTH-1:0] c_y,
  input  wire logic signed [COORD_WIDTH-1:0] d_x,
  input  wire logic signed [COORD_WIDTH-1:0] d_y,
  output logic signed [COORD_WIDTH:0]        op_p [sit_pkg::NUM_CROSS],
  output logic signed [COORD_WIDTH:0]        op_q [sit_pkg::NUM_CROSS],
  output logic signed [COORD_WIDTH:0]        op_r [sit_pkg::NUM_CROSS],
  output logic signed [COORD_WIDTH:0]        op_s [sit_pkg::NUM_CROSS],
  output sit_pkg::ctrl_t                     ctrl
);
  import sit_pkg::*;

  localparam int DW = COORD_WIDTH + 1;

  logic signed [COORD_WIDTH:0] p_next [NUM_CROSS];
  logic signed [COORD_WIDTH:0] q_next [NUM_CROSS];
  logic signed [COORD_WIDTH:0] r_next [NUM_CROSS];
  logic signed [COORD_WIDTH:0] s_next [NUM_CROSS];
  ctrl_t                       ctrl_next;

  function automatic logic signed [COORD_WIDTH:0] sub(
    input logic signed [COORD_WIDTH-1:0] x,
    input logic signed [COORD_WIDTH-1:0] y
  );
    return DW'(x) - DW'(y);
  endfunction

  function automatic logic between(
    input logic signed [COORD_WIDTH-1:0] v,
    input logic signed [COORD_WIDTH-1:0] e0,
    input logic signed [COORD_WIDTH-1:0] e1
  );
    return ((v >= e0) && (v <= e1)) || ((v >= e1) && (v <= e0));
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_CROSS; k++) begin
      p_next[k] = '0;
      q_next[k] = '0;
      r_next[k] = '0;
      s_next[k] = '0;
    end
    ctrl_next.btw = 1'b0;
    if (a_x == b_x && c_x == d_x) begin
      ctrl_next.mode = MODE_NONE;
    end else if (a_x == b_x) begin
      // AB vertical: compare ay and by against Sy on line CD
      ctrl_next.mode = MODE_VERT;
      ctrl_next.btw  = between(a_x, c_x, d_x);
      p_next[1] = sub(c_y, a_y); q_next[1] = sub(d_x, c_x);
      r_next[1] = sub(c_y, d_y); s_next[1] = sub(a_x, c_x);
      p_next[2] = sub(c_y, b_y); q_next[2] = sub(d_x, c_x);
      r_next[2] = sub(c_y, d_y); s_next[2] = sub(a_x, c_x);
    end else if (c_x == d_x) begin
      ctrl_next.mode = MODE_VERT;
      ctrl_next.btw  = between(c_x, a_x, b_x);
      p_next[1] = sub(a_y, c_y); q_next[1] = sub(b_x, a_x);
      r_next[1] = sub(a_y, b_y); s_next[1] = sub(c_x, a_x);
      p_next[2] = sub(a_y, d_y); q_next[2] = sub(b_x, a_x);
      r_next[2] = sub(a_y, b_y); s_next[2] = sub(c_x, a_x);
    end else begin
      ctrl_next.mode = MODE_GEN;
      // denominator r x s
      p_next[0] = sub(b_x, a_x); q_next[0] = sub(d_y, c_y);
      r_next[0] = sub(b_y, a_y); s_next[0] = sub(d_x, c_x);
      // t >= 0
      p_next[1] = sub(c_x, a_x); q_next[1] = sub(d_y, c_y);
      r_next[1] = sub(c_y, a_y); s_next[1] = sub(d_x, c_x);
      // t <= 1
      p_next[2] = sub(b_x, c_x); q_next[2] = sub(d_y, c_y);
      r_next[2] = sub(b_y, c_y); s_next[2] = sub(d_x, c_x);
      // u >= 0
      p_next[3] = sub(c_x, a_x); q_next[3] = sub(b_y, a_y);
      r_next[3] = sub(c_y, a_y); s_next[3] = sub(b_x, a_x);
      // u <= 1
      p_next[4] = sub(b_x, a_x); q_next[4] = sub(d_y, a_y);
      r_next[4] = sub(b_y, a_y); s_next[4] = sub(d_x, a_x);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_p <= p_next;
      op_q <= q_next;
      op_r <= r_next;
      op_s <= s_next;
      ctrl <= ctrl_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sit_cross.sv =====
`default_nettype none
module sit_cross #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en_mul,
  input  wire logic                        en_sub,
  input  wire logic signed [COORD_WIDTH:0] p,
  input  wire logic signed [COORD_WIDTH:0] q,
  input  wire logic signed [COORD_WIDTH:0] r,
  input  wire logic signed [COORD_WIDTH:0] s,
  output sit_pkg::sign_t                   sgn
);
  import sit_pkg::*;

  localparam int PW = 2 * COORD_WIDTH + 2;
  localparam int SW = PW + 1;

  logic signed [PW-1:0] pq;
  logic signed [PW-1:0] rs;
  logic signed [SW-1:0] diff;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      pq <= PW'(p) * PW'(q);
      rs <= PW'(r) * PW'(s);
    end
  end

  assign diff = SW'(pq) - SW'(rs);

  always_ff @(posedge clk) begin
    if (en_sub) begin
      sgn.neg <= diff[SW-1];
      sgn.nz  <= |diff;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sit_decide.sv =====
`default_nettype none
module sit_decide (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire sit_pkg::ctrl_t ctrl,
  input  wire sit_pkg::sign_t sg [sit_pkg::NUM_CROSS],
  output logic                hit
);
  import sit_pkg::*;

  logic hit_next;
  logic gen_ok;

  always_comb begin
    // denominator nonzero; every bound term must be zero or share the denominator's sign
    gen_ok = sg[0].nz;
    for (int k = 1; k < NUM_CROSS; k++) begin
      gen_ok = gen_ok && (!sg[k].nz || (sg[k].neg == sg[0].neg));
    end
  end

  always_comb begin
    case (ctrl.mode)
      MODE_GEN:  hit_next = gen_ok;
      // within the x range, miss only when both endpoints fall strictly on the same side of S
      MODE_VERT: hit_next = ctrl.btw &&
                            !(sg[1].nz && sg[2].nz && (sg[1].neg == sg[2].neg));
      default:   hit_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= hit_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/segment_intersection_test.sv =====
`default_nettype none
// 2D segment intersection test. Each transaction on seg_in carries segments
// AB and CD as signed COORD_WIDTH-bit endpoints; hit_out returns one bit per
// transaction, in order, set when the segments share a point (bounds included).
// Both segments vertical, or parallel non-vertical lines (collinear included),
// report no hit. All arithmetic is exact. The block is a four-stage pipeline
// (operand setup, multiply, subtract and sign, decision) that takes one
// transaction per cycle while hit_out is not stalling; backpressure on hit_out
// stalls the stages in place.
module segment_intersection_test #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  seg_if.sink       seg_in,
  hit_if.source     hit_out
);
  import sit_pkg::*;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic signed [COORD_WIDTH:0] op_p [NUM_CROSS];
  logic signed [COORD_WIDTH:0] op_q [NUM_CROSS];
  logic signed [COORD_WIDTH:0] op_r [NUM_CROSS];
  logic signed [COORD_WIDTH:0] op_s [NUM_CROSS];
  sign_t                       sg [NUM_CROSS];
  ctrl_t                       ctrl1, ctrl2, ctrl3;

  // a stage advances when it is empty or the one after it advances
  assign en4 = !v4 || hit_out.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign seg_in.ready  = en1;
  assign hit_out.valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= seg_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) ctrl2 <= ctrl1;
    if (en3) ctrl3 <= ctrl2;
  end

  sit_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk  (clk),
    .en   (en1),
    .a_x  (seg_in.a_x),
    .a_y  (seg_in.a_y),
    .b_x  (seg_in.b_x),
    .b_y  (seg_in.b_y),
    .c_x  (seg_in.c_x),
    .c_y  (seg_in.c_y),
    .d_x  (seg_in.d_x),
    .d_y  (seg_in.d_y),
    .op_p (op_p),
    .op_q (op_q),
    .op_r (op_r),
    .op_s (op_s),
    .ctrl (ctrl1)
  );

  for (genvar k = 0; k < NUM_CROSS; k++) begin : g_cross
    sit_cross #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_cross (
      .clk    (clk),
      .en_mul (en2),
      .en_sub (en3),
      .p      (op_p[k]),
      .q      (op_q[k]),
      .r      (op_r[k]),
      .s      (op_s[k]),
      .sgn    (sg[k])
    );
  end

  sit_decide u_decide (
    .clk  (clk),
    .en   (en4),
    .ctrl (ctrl3),
    .sg   (sg),
    .hit  (hit_out.hit)
  );

endmodule
`default_nettype wire

// ===== bench/segment_intersection_test_tb.sv =====
`timescale 1ns / 100ps
module segment_intersection_test_tb;

  localparam int COORD_WIDTH = 16;
  localparam int LATENCY     = 4;
  localparam int CYCLE_LIMIT = 500_000;
  localparam int PRINT_LIMIT = 40;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
    coord_t d_x;
    coord_t d_y;
  } seg_pair_t;

  typedef struct {
    seg_pair_t pair;
    bit        hit;
  } pending_t;

  logic clk = 1'b0;
  logic rst;

  seg_if #(.COORD_WIDTH(COORD_WIDTH)) seg_in ();
  hit_if hit_out ();

  segment_intersection_test #(.COORD_WIDTH(COORD_WIDTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .seg_in  (seg_in),
    .hit_out (hit_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pending_t pending_hits[$];
  int       err_count;
  int       pairs_sent;
  int       hits_seen;
  int       misses_seen;
  int       cycle_count;
  bit       tx_idle_on;
  bit       rx_idle_on;
  int       hold_request;
  int       hold_left;
  int       stall_left;

  // ---------------------------------------------------------------------------
  // Predictor: exact integer geometry on sign-extended coordinates
  // ---------------------------------------------------------------------------
  function automatic int sgn64(longint v);
    return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
  endfunction

  // sign of p*q - r*s; operands are at most 17 bits, so 64 bits are exact
  function automatic int cross_sign(longint p, longint q, longint r, longint s);
    return sgn64(p * q - r * s);
  endfunction

  function automatic bit in_span(longint v, longint e0, longint e1);
    longint lo;
    longint hi;
    lo = (e0 < e1) ? e0 : e1;
    hi = (e0 < e1) ? e1 : e0;
    return (v >= lo) && (v <= hi);
  endfunction

  // segment P is vertical at x = px, segment Q is not
  function automatic bit upright_hit(longint px, longint p0y, longint p1y,
                                     longint q0x, longint q0y, longint q1x, longint q1y);
    longint dq;
    int     orient;
    int     s0;
    int     s1;
    dq     = q1x - q0x;
    orient = sgn64(dq);
    if (!in_span(px, q0x, q1x)) return 1'b0;
    s0 = cross_sign(q0y - p0y, dq, q0y - q1y, px - q0x) * orient;
    s1 = cross_sign(q0y - p1y, dq, q0y - q1y, px - q0x) * orient;
    return !((s0 < 0 && s1 < 0) || (s0 > 0 && s1 > 0));
  endfunction

  function automatic bit pair_hits(seg_pair_t p);
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint rx, ry, sx, sy;
    int     den, t0, t1, u0, u1;
    ax = $signed(p.a_x);
    ay = $signed(p.a_y);
    bx = $signed(p.b_x);
    by = $signed(p.b_y);
    cx = $signed(p.c_x);
    cy = $signed(p.c_y);
    dx = $signed(p.d_x);
    dy = $signed(p.d_y);
    if (ax == bx && cx == dx) return 1'b0;
    if (ax == bx) return upright_hit(ax, ay, by, cx, cy, dx, dy);
    if (cx == dx) return upright_hit(cx, cy, dy, ax, ay, bx, by);
    rx  = bx - ax;
    ry  = by - ay;
    sx  = dx - cx;
    sy  = dy - cy;
    den = cross_sign(rx, sy, ry, sx);
    if (den == 0) return 1'b0;
    t0 = cross_sign(cx - ax, sy, cy - ay, sx) * den;
    t1 = cross_sign(bx - cx, sy, by - cy, sx) * den;
    u0 = cross_sign(cx - ax, ry, cy - ay, rx) * den;
    u1 = cross_sign(rx, dy - ay, ry, dx - ax) * den;
    return (t0 >= 0) && (t1 >= 0) && (u0 >= 0) && (u1 >= 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
    err_count++;
  endtask

  seg_pair_t seen_pair;
  pending_t  oldest;

  always @(posedge clk) begin
    if (!rst) begin
      // push first so a same-edge result still finds its entry
      if (seg_in.valid && seg_in.ready) begin
        seen_pair = '{seg_in.a_x, seg_in.a_y, seg_in.b_x, seg_in.b_y,
                      seg_in.c_x, seg_in.c_y, seg_in.d_x, seg_in.d_y};
        pending_hits.push_back('{pair: seen_pair, hit: pair_hits(seen_pair)});
        pairs_sent++;
      end
      if (hit_out.valid && hit_out.ready) begin
        if (pending_hits.size() == 0) begin
          report_mismatch($sformatf("result hit=%0b with no pair outstanding", hit_out.hit));
        end else begin
          oldest = pending_hits.pop_front();
          if (hit_out.hit !== oldest.hit) begin
            report_mismatch($sformatf(
              "hit %0b, predicted %0b for A(%0d,%0d) B(%0d,%0d) C(%0d,%0d) D(%0d,%0d)",
              hit_out.hit, oldest.hit, oldest.pair.a_x, oldest.pair.a_y,
              oldest.pair.b_x, oldest.pair.b_y, oldest.pair.c_x, oldest.pair.c_y,
              oldest.pair.d_x, oldest.pair.d_y));
          end
          if (oldest.hit) hits_seen++;
          else misses_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_hits.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts plus a long hold on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hit_out.ready <= 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      hit_out.ready <= 1'b0;
      stall_left--;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      hit_out.ready <= 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      hit_out.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_pair(input seg_pair_t p);
    seg_in.valid <= 1'b1;
    seg_in.a_x   <= p.a_x;
    seg_in.a_y   <= p.a_y;
    seg_in.b_x   <= p.b_x;
    seg_in.b_y   <= p.b_y;
    seg_in.c_x   <= p.c_x;
    seg_in.c_y   <= p.c_y;
    seg_in.d_x   <= p.d_x;
    seg_in.d_y   <= p.d_y;
    @(posedge clk);
    while (!seg_in.ready) @(posedge clk);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      seg_in.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_coords(input int ax, input int ay, input int bx, input int by,
                             input int cx, input int cy, input int dx, input int dy);
    send_pair('{coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
                coord_t'(cx), coord_t'(cy), coord_t'(dx), coord_t'(dy)});
  endtask

  // drop valid and hold until every outstanding result has come back
  task automatic drain_results();
    seg_in.valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic int rand_int(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_span();
    case ($urandom_range(0, 2))
      0:       return 8;
      1:       return 300;
      default: return 32767;
    endcase
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return int'(coord_t'($urandom));
    endcase
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int        span, px, py, vx, vy, wx, wy, k;
    span = pick_span();
    p = '{coord_t'(rand_int(span)), coord_t'(rand_int(span)),
          coord_t'(rand_int(span)), coord_t'(rand_int(span)),
          coord_t'(rand_int(span)), coord_t'(rand_int(span)),
          coord_t'(rand_int(span)), coord_t'(rand_int(span))};
    case ($urandom_range(0, 11))
      0: p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
      1: ;
      2: p.b_x = p.a_x;
      3: p.d_x = p.c_x;
      4: begin
        p.b_x = p.a_x;
        p.d_x = ($urandom_range(0, 1) == 0) ? p.a_x : p.c_x;
      end
      5: begin
        // parallel or collinear
        px = rand_int(1000);
        py = rand_int(1000);
        vx = rand_int(100);
        vy = rand_int(100);
        k  = rand_int(3);
        p.a_x = coord_t'(px);
        p.a_y = coord_t'(py);
        p.b_x = coord_t'(px + vx);
        p.b_y = coord_t'(py + vy);
        if ($urandom_range(0, 1) == 0) begin
          p.c_x = coord_t'(px + 2 * vx);
          p.c_y = coord_t'(py + 2 * vy);
        end
        p.d_x = coord_t'(int'(p.c_x) + k * vx);
        p.d_y = coord_t'(int'(p.c_y) + k * vy);
      end
      6: begin
        if ($urandom_range(0, 1) == 0) begin
          p.c_x = p.a_x;
          p.c_y = p.a_y;
        end else begin
          p.d_x = p.b_x;
          p.d_y = p.b_y;
        end
      end
      7: p = '{coord_t'(extreme_coord()), coord_t'(extreme_coord()),
               coord_t'(extreme_coord()), coord_t'(extreme_coord()),
               coord_t'(extreme_coord()), coord_t'(extreme_coord()),
               coord_t'(extreme_coord()), coord_t'(extreme_coord())};
      default: begin
        // both segments pass through P; in some cases C lands on P
        span = (span > 16000) ? 16000 : span;
        px = rand_int(16000);
        py = rand_int(16000);
        vx = rand_int(span);
        vy = rand_int(span);
        wx = rand_int(span);
        wy = rand_int(span);
        p.a_x = coord_t'(px - vx);
        p.a_y = coord_t'(py - vy);
        p.b_x = coord_t'(px + vx);
        p.b_y = coord_t'(py + vy);
        if ($urandom_range(0, 2) == 0) begin
          p.c_x = coord_t'(px);
          p.c_y = coord_t'(py);
        end else begin
          p.c_x = coord_t'(px - wx);
          p.c_y = coord_t'(py - wy);
        end
        p.d_x = coord_t'(px + wx);
        p.d_y = coord_t'(py + wy);
      end
    endcase
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic run_directed_cases();
    send_coords(0, 0, 10, 10, 0, 10, 10, 0);          // plain crossing
    send_coords(0, 0, 4, 4, 4, 4, 8, 0);              // shared endpoint
    send_coords(0, 0, 8, 0, 4, 0, 6, 5);              // endpoint on the other segment
    send_coords(0, 0, 2, 2, 5, 0, 4, 1);              // lines cross outside both
    send_coords(3, 0, 3, 9, 3, 2, 3, 5);              // both vertical, overlapping
    send_coords(0, 0, 5, 5, 0, 1, 5, 6);              // parallel, apart
    send_coords(0, 0, 6, 6, 2, 2, 8, 8);              // collinear, overlapping
    send_coords(2, -5, 2, 5, 0, 0, 4, 1);             // first vertical, crossing
    send_coords(2, 5, 2, 9, 0, 0, 4, 1);              // first vertical, miss in y
    send_coords(-4, -4, 4, 4, 0, -1, 0, 1);           // second vertical, crossing
    send_coords(0, 0, 4, 4, 6, 0, 6, 9);              // second vertical, x out of span
    send_coords(2, 2, 2, 2, 0, 0, 4, 4);              // point on the other segment
    send_coords(2, 3, 2, 3, 0, 0, 4, 4);              // point off the other segment
    send_coords(1, 1, 1, 1, 1, 1, 1, 1);              // two coincident points
    send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    send_coords(-32768, 0, 32767, 0, 0, -32768, 1, 32767);
    send_coords(-32768, -32768, 32767, -32767, -32768, -32767, 32767, -32768);
    send_coords(-32768, -32768, 32767, -32767, -32768, -32766, 32767, -32765);
    send_coords(32767, -32768, 32767, 32767, -32768, 0, 32767, 1);
    send_coords(-32768, -32768, -32768, 32767, -32768, 32767, 32767, -32768);
    send_coords(10, 0, 0, 10, 0, 0, 10, 10);          // reversed direction
    send_coords(2, 0, 2, 4, 0, 6, 4, 2);              // touch at the vertical's end
    send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
    drain_results();
  endtask

  task automatic run_random_shapes(input int count);
    repeat (count) send_pair(random_pair());
    drain_results();
  endtask

  // stall the result side long enough to fill the pipeline and block input
  task automatic run_output_hold(input int count);
    tx_idle_on   = 1'b0;
    hold_request = 400;
    repeat (count) send_pair(random_pair());
    tx_idle_on = 1'b1;
    drain_results();
  endtask

  task automatic run_drain_pauses(input int rounds, input int per_round);
    repeat (rounds) begin
      repeat (per_round) send_pair(random_pair());
      drain_results();
    end
  endtask

  task automatic run_full_rate(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_pair(random_pair());
    drain_results();
  endtask

  initial begin
    rst           = 1'b1;
    seg_in.valid  = 1'b0;
    seg_in.a_x    = '0;
    seg_in.a_y    = '0;
    seg_in.b_x    = '0;
    seg_in.b_y    = '0;
    seg_in.c_x    = '0;
    seg_in.c_y    = '0;
    seg_in.d_x    = '0;
    seg_in.d_y    = '0;
    hit_out.ready = 1'b0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed_cases();
    run_random_shapes(1400);
    run_output_hold(150);
    run_drain_pauses(4, 25);
    run_full_rate(280);

    if (pending_hits.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_hits.size()));
    $display("Checked %0d segment pairs: %0d intersecting, %0d apart", pairs_sent,
             hits_seen, misses_seen);
    $display("Covered special cases, random shapes, output hold-off, drains, full rate");
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sit_pkg.sv
rtl/sit_ifs.sv
rtl/sit_prep.sv
rtl/sit_cross.sv
rtl/sit_decide.sv
rtl/segment_intersection_test.sv
bench/segment_intersection_test_tb.sv
